>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, off while reset is held.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a trigger implies a consequent in the same cycle.
`define ASSERT_IMP(lbl, clk, rstn, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |-> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rfpc_pkg.sv
// Shared codes, control word type and microcode table of the ring FIFO checker.
package rfpc_pkg;

    // Action codes carried on the input channel.
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_CHECK  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Microcode step addresses.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_FETCH   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_INS     = 4'd1;
    localparam logic [STEP_W-1:0] STEP_REM     = 4'd2;
    localparam logic [STEP_W-1:0] STEP_REM_POP = 4'd3;
    localparam logic [STEP_W-1:0] STEP_CHK     = 4'd4;
    localparam logic [STEP_W-1:0] STEP_CHK_RDI = 4'd5;
    localparam logic [STEP_W-1:0] STEP_CHK_RDJ = 4'd6;
    localparam logic [STEP_W-1:0] STEP_CHK_CMP = 4'd7;
    localparam logic [STEP_W-1:0] STEP_NOP     = 4'd8;

    // Datapath operations.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_REM_ISSUE,
        OP_REM_POP,
        OP_CHK_INIT,
        OP_RD_I,
        OP_RD_J,
        OP_CMP
    } op_t;

    // Sequencing modes.
    typedef enum logic [1:0] {
        J_SEQ,   // go to the following step
        J_DISP,  // wait for a transaction, then branch on its action
        J_END,   // emit the result, back to fetch
        J_TEST   // condition true: emit and fetch; else go to target
    } jmp_t;

    typedef struct packed {
        op_t               op;
        jmp_t              jmp;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    function automatic ctrl_t rfpc_rom(input logic [STEP_W-1:0] addr);
        ctrl_t w;
        unique case (addr)
            STEP_FETCH:   w = '{OP_NONE,      J_DISP, STEP_FETCH};
            STEP_INS:     w = '{OP_INSERT,    J_END,  STEP_FETCH};
            STEP_REM:     w = '{OP_REM_ISSUE, J_TEST, STEP_REM_POP};
            STEP_REM_POP: w = '{OP_REM_POP,   J_END,  STEP_FETCH};
            STEP_CHK:     w = '{OP_CHK_INIT,  J_TEST, STEP_CHK_RDI};
            STEP_CHK_RDI: w = '{OP_RD_I,      J_SEQ,  STEP_FETCH};
            STEP_CHK_RDJ: w = '{OP_RD_J,      J_SEQ,  STEP_FETCH};
            STEP_CHK_CMP: w = '{OP_CMP,       J_TEST, STEP_CHK_RDI};
            STEP_NOP:     w = '{OP_NONE,      J_END,  STEP_FETCH};
            default:      w = '{OP_NONE,      J_END,  STEP_FETCH};
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/ring_fifo_palindrome_check_unit.sv
// Top level of the ring byte FIFO with palindrome check, microcoded control.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------
//  s_      | in        | s_tvalid / s_tready | tuser: action; tdata: char_value
//  m_      | out       | m_tvalid / m_tready | tuser: status; tdata: data, pal, flags
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_data: capacity
//
// Steps: fetch, then the action; a remove pops after its read unless empty; a check
//   walks read, read, compare per pair on the single RAM read port.
// Reset: aresetn low clears pointers, count and output valid; capacity
//   returns to 64 (or DEPTH if smaller). Storage is not cleared.
// Stalls: an emitting step holds while a result waits on m_; input and capacity
//   writes are taken only in the fetch step, a capacity write first.
`include "assert_macros.svh"

module ring_fifo_palindrome_check_unit
    import rfpc_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] action
    input  logic [7:0]  s_tdata,   // [7:0] char_value
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic [15:0] m_tdata,   // [7:0] data_out, [8] palindrome, [9] empty_res,
                                   // [10] full_res, [15:11] zero
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data   // [6:0] capacity
);

    localparam int AW      = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMP_W   = (CNT_W > 7) ? CNT_W : 7;
    localparam int CAP_RST = (DEPTH < 64) ? DEPTH : 64;

    // Advance a ring index, wrapping at the capacity.
    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] x,
                                              input logic [CNT_W-1:0] c);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(x) + (CNT_W + 1)'(1);
        if (s >= (CNT_W + 1)'(c)) begin
            return '0;
        end
        return AW'(s);
    endfunction

    // Step a ring index back, wrapping to the last slot within the capacity.
    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] x,
                                              input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] last;
        last = c - CNT_W'(1);
        if (x == '0 || CNT_W'(x) >= c) begin
            return AW'(last);
        end
        return x - AW'(1);
    endfunction

    // sequencer and input latch
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]        act_reg;
    logic [7:0]        char_reg;
    ctrl_t             cw;

    // queue state
    logic [CNT_W-1:0]  cap_reg;
    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    // check walker
    logic [AW-1:0]     i_reg, i_next;
    logic [AW-1:0]     j_reg, j_next;
    logic [CNT_W-1:0]  pairs_reg, pairs_next;
    logic [7:0]        a_reg;

    // output register
    logic              m_valid_reg;
    logic [1:0]        m_status_reg;
    logic [7:0]        m_data_reg;
    logic              m_pal_reg, m_empty_reg, m_full_reg;

    // RAM port
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [7:0]        ram_rdata;

    // control
    logic              s_accept, cond, emit, stall, adv, full_now;
    logic [1:0]        res_status;
    logic [7:0]        res_data;
    logic              res_pal;
    logic [CMP_W-1:0]  cap_wr;

    assign cw        = rfpc_rom(step_reg);
    // hold off the input while a capacity write is offered
    assign s_tready  = (step_reg == STEP_FETCH) && !cfg_valid;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = (step_reg == STEP_FETCH);
    assign full_now  = (count_reg >= cap_reg);

    // Datapath: one operation per control word.
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        pairs_next = pairs_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = head_reg;
        cond       = 1'b0;
        res_status = ST_DONE;
        res_data   = '0;
        res_pal    = 1'b0;
        unique case (cw.op)
            OP_INSERT: begin
                if (full_now) begin
                    res_status = ST_FULL;
                end else begin
                    ram_we     = 1'b1;
                    tail_next  = idx_inc(tail_reg, cap_reg);
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_REM_ISSUE: begin
                ram_re = 1'b1;
                cond   = (count_reg == '0);
                res_status = ST_EMPTY;
            end
            OP_REM_POP: begin
                res_data   = ram_rdata;
                head_next  = idx_inc(head_reg, cap_reg);
                count_next = count_reg - CNT_W'(1);
            end
            OP_CHK_INIT: begin
                i_next     = head_reg;
                j_next     = idx_dec(tail_reg, cap_reg);
                pairs_next = count_reg >> 1;
                cond       = (count_reg < CNT_W'(2));
                res_pal    = 1'b1;
            end
            OP_RD_I: begin
                ram_re    = 1'b1;
                ram_raddr = i_reg;
            end
            OP_RD_J: begin
                ram_re    = 1'b1;
                ram_raddr = j_reg;
            end
            OP_CMP: begin
                res_pal = (a_reg == ram_rdata);
                cond    = !res_pal || (pairs_reg == CNT_W'(1));
                i_next     = idx_inc(i_reg, cap_reg);
                j_next     = idx_dec(j_reg, cap_reg);
                pairs_next = pairs_reg - CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    // Sequencer: emit on end steps and taken tests; hold an emit while m_ is full.
    assign emit  = (cw.jmp == J_END) || ((cw.jmp == J_TEST) && cond);
    assign stall = emit && m_valid_reg && !m_tready;
    assign adv   = (step_reg == STEP_FETCH) ? s_accept : !stall;

    always_comb begin
        step_next = step_reg;
        unique case (cw.jmp)
            J_SEQ:  step_next = step_reg + STEP_W'(1);
            J_DISP: begin
                unique case (s_tuser)
                    ACT_INSERT: step_next = STEP_INS;
                    ACT_REMOVE: step_next = STEP_REM;
                    ACT_CHECK:  step_next = STEP_CHK;
                    default:    step_next = STEP_NOP;
                endcase
            end
            J_END:  step_next = STEP_FETCH;
            J_TEST: step_next = cond ? STEP_FETCH : cw.target;
            default: step_next = STEP_FETCH;
        endcase
    end

    // Clamp a written capacity to 1..DEPTH.
    always_comb begin
        cap_wr = CMP_W'(cfg_data);
        if (cap_wr == '0) begin
            cap_wr = CMP_W'(1);
        end else if (cap_wr > CMP_W'(DEPTH)) begin
            cap_wr = CMP_W'(DEPTH);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= STEP_FETCH;
            cap_reg     <= CNT_W'(CAP_RST);
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                step_reg <= step_next;
            end
            // a write empties the queue; only taken while idle
            if (cfg_valid && cfg_ready) begin
                cap_reg   <= CNT_W'(cap_wr);
                head_reg  <= '0;
                tail_reg  <= '0;
                count_reg <= '0;
            end else if (adv) begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
            if (adv && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            act_reg  <= s_tuser;
            char_reg <= s_tdata;
        end
        if (adv) begin
            i_reg     <= i_next;
            j_reg     <= j_next;
            pairs_reg <= pairs_next;
        end
        // first byte of the pair arrives while the second read is issued
        if (cw.op == OP_RD_J) begin
            a_reg <= ram_rdata;
        end
        if (adv && emit) begin
            m_status_reg <= res_status;
            m_data_reg   <= res_data;
            m_pal_reg    <= res_pal;
            m_empty_reg  <= (count_next == '0);
            m_full_reg   <= (count_next >= cap_reg);
        end
    end

    rfpc_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we && adv),
        .waddr (tail_reg),
        .wdata (char_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {5'b0, m_full_reg, m_empty_reg, m_pal_reg, m_data_reg};

    // The latched action is only a debug aid of the dispatch; keep it consistent.
    `ASSERT_IMP(a_disp_match, aclk, aresetn, (step_reg == STEP_INS), (act_reg == ACT_INSERT), "insert step without insert action")
    `ASSERT_CLK(a_count_cap, aclk, aresetn, (count_reg <= cap_reg), "entry count above capacity")
    `ASSERT_CLK(a_head_range, aclk, aresetn, (CNT_W'(head_reg) < cap_reg), "head index outside capacity")
    `ASSERT_IMP(a_emit_free, aclk, aresetn, (adv && emit), (!m_valid_reg || m_tready), "result emitted over a pending one")
    `ASSERT_IMP(a_cmp_pairs, aclk, aresetn, (step_reg == STEP_CHK_CMP), (pairs_reg != '0), "compare step with no pair left")

endmodule

>>> hw/rtl/rfpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rfpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        // hold read data when no read is issued
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sim/ring_fifo_palindrome_check_unit_tb.sv
// Self-checking testbench of the ring byte FIFO with palindrome check.
module ring_fifo_palindrome_check_unit_tb;
    import rfpc_pkg::*;

    localparam int          DEPTH        = 64;
    localparam logic [1:0]  ACT_UNUSED   = 2'd3;
    localparam int          HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int          STALL_LIMIT  = 3000;  // cycles with no transaction at all
    localparam int          PHASE_ITEMS  = 106;
    localparam int          NUM_PHASES   = 13;
    localparam int          TAIL_CYCLES  = 200;   // > longest check walk plus margin

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] data_out;
        logic       palindrome;
        logic       empty_res;
        logic       full_res;
    } ring_reply_t;

    // Mirror of the ring: storage, pointers and capacity, plus the replies still owed.
    class ring_fifo_shadow;
        logic [7:0]  storage [DEPTH];
        int unsigned head_idx;
        int unsigned tail_idx;
        int unsigned fill;
        logic [6:0]  cap_reg;
        ring_reply_t replies [$];
        int          errors;

        function new();
            foreach (storage[n]) storage[n] = 8'h00;
            head_idx = 0;
            tail_idx = 0;
            fill     = 0;
            cap_reg  = 7'd64;
            errors   = 0;
        endfunction

        function int unsigned live_cap();
            if (cap_reg == 0) return 1;
            if (cap_reg > DEPTH) return DEPTH;
            return cap_reg;
        endfunction

        function int unsigned fwd(int unsigned i, int unsigned cap);
            return (i + 1 >= cap) ? 0 : i + 1;
        endfunction

        function int unsigned back(int unsigned i, int unsigned cap);
            return (i == 0 || i >= cap) ? cap - 1 : i - 1;
        endfunction

        // A capacity write empties the ring; storage is kept.
        function void set_capacity(logic [6:0] v);
            cap_reg  = v;
            head_idx = 0;
            tail_idx = 0;
            fill     = 0;
        endfunction

        function void take_action(logic [1:0] act, logic [7:0] ch);
            ring_reply_t r;
            int unsigned cap;
            int unsigned i;
            int unsigned j;
            cap = live_cap();
            r = '0;
            r.status = ST_DONE;
            case (act)
                ACT_INSERT: begin
                    if (fill >= cap) begin
                        r.status = ST_FULL;
                    end else begin
                        storage[tail_idx] = ch;
                        tail_idx = fwd(tail_idx, cap);
                        fill++;
                    end
                end
                ACT_REMOVE: begin
                    if (fill == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.data_out = storage[head_idx];
                        head_idx = fwd(head_idx, cap);
                        fill--;
                    end
                end
                ACT_CHECK: begin
                    // walk inward; the middle pair of an even fill is compared too
                    i = head_idx;
                    j = back(tail_idx, cap);
                    r.palindrome = 1'b1;
                    for (int k = 0; k < fill / 2; k++) begin
                        if (storage[i] != storage[j]) begin
                            r.palindrome = 1'b0;
                            break;
                        end
                        i = fwd(i, cap);
                        j = back(j, cap);
                    end
                end
                default: ;  // unused action: state untouched
            endcase
            r.empty_res = (fill == 0);
            r.full_res  = (fill >= cap);
            replies.push_back(r);
        endfunction

        function void compare_reply(logic [1:0] tuser, logic [15:0] tdata);
            ring_reply_t e;
            if (replies.size() == 0) begin
                $error("result with no item waiting: status %0d tdata 0x%04h", tuser, tdata);
                errors++;
                return;
            end
            e = replies.pop_front();
            if (tuser !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, tuser);
                errors++;
            end
            if (tdata[7:0] !== e.data_out) begin
                $error("data_out: expected 0x%02h, actual 0x%02h", e.data_out, tdata[7:0]);
                errors++;
            end
            if (tdata[8] !== e.palindrome) begin
                $error("palindrome: expected %0d, actual %0d", e.palindrome, tdata[8]);
                errors++;
            end
            if (tdata[9] !== e.empty_res) begin
                $error("empty_res: expected %0d, actual %0d", e.empty_res, tdata[9]);
                errors++;
            end
            if (tdata[10] !== e.full_res) begin
                $error("full_res: expected %0d, actual %0d", e.full_res, tdata[10]);
                errors++;
            end
            if (tdata[15:11] !== 5'd0) begin
                $error("tdata padding: expected 0, actual 0x%02h", tdata[15:11]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser   = 2'd0;
    logic [7:0]  s_tdata   = 8'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [1:0]  m_tuser;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data  = 7'd0;

    ring_fifo_shadow shadow = new();

    // Stimulus-side view of the ring contents, used to shape well-formed runs.
    logic [7:0]  gen_q [$];
    int unsigned gen_cap      = DEPTH;
    int          items_sent   = 0;
    bit          src_idle_on  = 1'b1;
    bit          sink_idle_on = 1'b1;
    bit          sink_hold    = 1'b0;
    int          quiet_cycles = 0;

    always #5 aclk = ~aclk;

    ring_fifo_palindrome_check_unit #(
        .DEPTH(DEPTH)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Sample every channel at the edge; also count cycles with no transaction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) shadow.set_capacity(cfg_data);
            if (s_tvalid && s_tready) shadow.take_action(s_tuser, s_tdata);
            if (m_tvalid && m_tready) shadow.compare_reply(m_tuser, m_tdata);
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Receiver: long hold-off on request, random stall bursts, or ready.
    initial begin
        forever begin
            if (sink_hold) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                sink_hold = 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Offer one item and hold it until accepted; maybe idle afterwards.
    task automatic offer(input logic [1:0] act, input logic [7:0] ch);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= ch;
        do @(posedge aclk); while (!s_tready);
        if (act == ACT_INSERT) begin
            if (gen_q.size() < gen_cap) gen_q.push_back(ch);
        end else if (act == ACT_REMOVE) begin
            if (gen_q.size() != 0) void'(gen_q.pop_front());
        end
        items_sent++;
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every owed result has arrived.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (shadow.replies.size() != 0) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [6:0] v);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        gen_q.delete();
        gen_cap = (v == 0) ? 1 : ((v > DEPTH) ? DEPTH : v);
        @(posedge aclk);
    endtask

    // Empty the ring, fill it with a palindrome (sometimes one bit off), check it.
    task automatic build_palindrome();
        logic [7:0] word [DEPTH];
        int         len;
        int         lim;
        int         n;
        n = gen_q.size();
        repeat (n) offer(ACT_REMOVE, 8'($urandom));
        if ($urandom_range(0, 3) == 0) offer(ACT_REMOVE, 8'($urandom));
        lim = (gen_cap < 8) ? gen_cap : 8;
        len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, lim) : gen_cap;
        for (int k = 0; k < (len + 1) / 2; k++) begin
            word[k] = 8'($urandom);
            word[len - 1 - k] = word[k];
        end
        if (len >= 2 && $urandom_range(0, 1) == 1)
            word[$urandom_range(0, len - 1)] ^= 8'(1 << $urandom_range(0, 7));
        for (int k = 0; k < len; k++) offer(ACT_INSERT, word[k]);
        offer(ACT_CHECK, 8'($urandom));
        if ($urandom_range(0, 2) == 0) offer(ACT_INSERT, 8'($urandom));
    endtask

    task automatic run_phase(input int n);
        int target;
        int pick;
        target = items_sent + n;
        while (items_sent < target) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                build_palindrome();
            end else if (pick < 8) begin
                repeat ($urandom_range(3, 15))
                    offer(2'($urandom_range(0, 3)), 8'($urandom));
            end else begin
                offer(ACT_CHECK, 8'($urandom));
            end
        end
    endtask

    initial begin
        logic [6:0] phase_caps [NUM_PHASES];
        logic [6:0] cap;
        phase_caps = '{7'd64, 7'd1, 7'd2, 7'd8, 7'd0, 7'd127, 7'd3, 7'd33,
                       7'd64, 7'd0, 7'd0, 7'd5, 7'd16};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset capacity, empty check, empty remove, unused action.
        offer(ACT_CHECK,  8'h00);
        offer(ACT_REMOVE, 8'hFF);
        offer(ACT_UNUSED, 8'h5A);
        offer(ACT_INSERT, 8'h00);
        offer(ACT_INSERT, 8'hFF);
        offer(ACT_CHECK,  8'h00);
        offer(ACT_REMOVE, 8'h00);
        offer(ACT_REMOVE, 8'h00);
        // even fill whose middle pair differs
        offer(ACT_INSERT, 8'h61);
        offer(ACT_INSERT, 8'h62);
        offer(ACT_INSERT, 8'h63);
        offer(ACT_INSERT, 8'h61);
        offer(ACT_CHECK,  8'h00);
        // small ring: even palindrome, reject when full; the write empties the ring
        write_capacity(7'd4);
        offer(ACT_INSERT, 8'h61);
        offer(ACT_INSERT, 8'h62);
        offer(ACT_INSERT, 8'h62);
        offer(ACT_INSERT, 8'h61);
        offer(ACT_CHECK,  8'h00);
        offer(ACT_INSERT, 8'h07);
        offer(ACT_CHECK,  8'h00);
        // zero capacity acts as one entry
        write_capacity(7'd0);
        offer(ACT_INSERT, 8'hAA);
        offer(ACT_INSERT, 8'h55);
        offer(ACT_REMOVE, 8'h00);
        // capacity above the depth acts as the depth
        write_capacity(7'd127);
        offer(ACT_INSERT, 8'h01);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == 9)       cap = 7'($urandom_range(1, 64));
            else if (phase == 10) cap = 7'($urandom_range(0, 127));
            else                  cap = phase_caps[phase];
            write_capacity(cap);
            // last phases run with no idling on either side
            src_idle_on  = (phase < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            sink_idle_on = (phase < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            if (phase == 2) sink_hold = 1'b1;
            if (phase == 5) begin
                run_phase(PHASE_ITEMS / 2);
                wait_drain();
                run_phase(PHASE_ITEMS / 2);
            end else begin
                run_phase(PHASE_ITEMS);
            end
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (shadow.replies.size() != 0) begin
            $error("%0d results never arrived", shadow.replies.size());
            shadow.errors++;
        end
        if (shadow.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> ring_fifo_palindrome_check_unit.f
+incdir+hw/rtl
hw/rtl/rfpc_pkg.sv
hw/rtl/rfpc_ram.sv
hw/rtl/ring_fifo_palindrome_check_unit.sv
sim/ring_fifo_palindrome_check_unit_tb.sv
